FILE: design/dwpp_pkg.sv
`default_nettype none
package dwpp_pkg;

    localparam int CNT_W   = 16;
    localparam int Q8_W    = 16;
    localparam int GAIN_W  = 32;
    localparam int ERR_W   = 17;
    localparam int INTEG_W = 32;
    localparam int PWM_W   = 8;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RAMP_W  = 4;

    // speed = round(delta * 256 / 228): (|delta|*128 + 57) / 114 via reciprocal
    localparam logic [29:0] SPD_RECIP = 30'd602802428;
    localparam int          SPD_SHIFT = 36;
    localparam logic [6:0]  SPD_BIAS  = 7'd57;

    localparam logic [19:0] COEF_A = 20'd749076;
    localparam logic [31:0] OFFS_A = 32'd2199996334;
    localparam logic [19:0] COEF_B = 20'd743178;
    localparam logic [31:0] OFFS_B = 32'd2162603622;

    localparam logic [PWM_W-1:0]  PWM_IDLE   = 8'd131;
    localparam logic [PWM_W-1:0]  PWM_MAX    = 8'd255;
    localparam logic [RAMP_W-1:0] RAMP_STEPS = 4'd12;

    localparam logic [2:0] CFG_PROP_A   = 3'd0;
    localparam logic [2:0] CFG_PROP_B   = 3'd1;
    localparam logic [2:0] CFG_INTEG    = 3'd2;
    localparam logic [2:0] CFG_DERIV    = 3'd3;
    localparam logic [2:0] CFG_UPPER    = 3'd4;
    localparam logic [2:0] CFG_LOWER    = 3'd5;

    localparam logic [GAIN_W-1:0] RST_PROP  = 32'd15938355;
    localparam logic [GAIN_W-1:0] RST_INTEG = 32'd13;
    localparam logic [GAIN_W-1:0] RST_DERIV = 32'd1118481067;
    localparam logic [Q8_W-1:0]   RST_UPPER = 16'h0A00;
    localparam logic [Q8_W-1:0]   RST_LOWER = 16'hF600;

    typedef struct packed {
        logic signed [CNT_W-1:0] count_a;
        logic signed [CNT_W-1:0] count_b;
        logic signed [Q8_W-1:0]  target_a;
        logic signed [Q8_W-1:0]  target_b;
        logic                    ramp_restart;
    } t_in_beat;

    typedef struct packed {
        logic [PWM_W-1:0]       pwm_a;
        logic [PWM_W-1:0]       pwm_b;
        logic signed [Q8_W-1:0] drive_a;
        logic signed [Q8_W-1:0] drive_b;
        logic                   ramping;
    } t_out_beat;

    typedef struct packed {
        logic [GAIN_W-1:0]      kp;
        logic [GAIN_W-1:0]      ki;
        logic [GAIN_W-1:0]      kd;
        logic signed [Q8_W-1:0] upper;
        logic signed [Q8_W-1:0] lower;
    } t_pid_cfg;

    typedef struct packed {
        logic [PWM_W-1:0]       pwm;
        logic signed [Q8_W-1:0] drive;
    } t_lane_res;

    function automatic logic [PWM_W-1:0] ramp_pwm(input logic [RAMP_W-1:0] step);
        logic [PWM_W-1:0] v;
        case (step)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd255;
            4'd2:    v = 8'd245;
            4'd3:    v = 8'd235;
            4'd4:    v = 8'd230;
            4'd5:    v = 8'd225;
            4'd6:    v = 8'd220;
            4'd7:    v = 8'd215;
            4'd8:    v = 8'd210;
            4'd9:    v = 8'd205;
            4'd10:   v = 8'd195;
            4'd11:   v = 8'd185;
            default: v = 8'd175;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/dwpp_lane.sv
`default_nettype none
module dwpp_lane (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_sel_b,
    input  wire logic signed [15:0]   i_count,
    input  wire logic signed [15:0]   i_target,
    input  wire dwpp_pkg::t_pid_cfg   i_cfg,
    input  wire logic                 i_take,
    output logic                      o_done,
    output dwpp_pkg::t_lane_res       o_res
);

    typedef enum logic [3:0] {
        L_IDLE, L_SPD, L_QUOT, L_INT, L_PROP, L_DER, L_SUM, L_DRV, L_PWM, L_FIN
    } t_lstate;

    localparam int PW = dwpp_pkg::PROD_W;

    t_lstate                 r_state;
    logic [15:0]             r_prev;
    logic signed [15:0]      r_target;
    logic                    r_neg;
    logic [22:0]             r_x;
    logic signed [PW-1:0]    r_prod;
    logic signed [15:0]      r_speed;
    logic signed [16:0]      r_err;
    logic signed [17:0]      r_derr;
    logic signed [16:0]      r_perr;
    logic signed [31:0]      r_integ;
    logic signed [PW-1:0]    r_acc;
    logic signed [15:0]      r_drive;
    logic signed [16:0]      r_s;

    logic [15:0]             delta;
    logic signed [16:0]      delta_s;
    logic [16:0]             mag;
    logic [22:0]             x_in;
    logic [15:0]             quot;
    logic signed [17:0]      spd_w;
    logic signed [15:0]      spd_sat;
    logic signed [16:0]      err;
    logic signed [PW-1:0]    inc_pre;
    logic signed [PW-1:0]    inc;
    logic signed [PW-1:0]    isum;
    logic signed [PW-1:0]    iup;
    logic signed [PW-1:0]    ilo;
    logic signed [31:0]      integ_n;
    logic signed [PW-1:0]    drv_pre;
    logic signed [PW-1:0]    drv_sh;
    logic signed [PW-1:0]    dup;
    logic signed [PW-1:0]    dlo;
    logic signed [15:0]      drive_n;
    logic [19:0]             coef;
    logic [31:0]             offs;
    logic signed [PW-1:0]    pwm_pre;
    logic signed [PW-1:0]    pwm_sh;
    logic [7:0]              pwm_v;
    logic signed [32:0]      mul_a;
    logic signed [23:0]      mul_b;
    logic signed [PW-1:0]    mul_p;

    assign coef = i_sel_b ? dwpp_pkg::COEF_B : dwpp_pkg::COEF_A;
    assign offs = i_sel_b ? dwpp_pkg::OFFS_B : dwpp_pkg::OFFS_A;

    // count change, wrapped to 16 bits, taken apart into sign and magnitude
    always_comb begin
        delta   = i_count - r_prev;
        delta_s = {delta[15], delta};
        mag     = delta[15] ? 17'(-delta_s) : 17'(delta_s);
        x_in    = {mag[15:0], 7'b0} + {16'b0, dwpp_pkg::SPD_BIAS};
    end

    always_comb begin
        quot    = r_prod[dwpp_pkg::SPD_SHIFT +: 16];
        spd_w   = r_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        if (spd_w > 18'sd32767) begin
            spd_sat = 16'sh7FFF;
        end else if (spd_w < -18'sd32768) begin
            spd_sat = 16'sh8000;
        end else begin
            spd_sat = spd_w[15:0];
        end
        err = {r_target[15], r_target} - {spd_sat[15], spd_sat};
    end

    // integral: add the rounded increment, clamp to the Q7.24 limits
    always_comb begin
        inc_pre = r_prod + PW'(128);
        inc     = inc_pre >>> 8;
        isum    = {{(PW-32){r_integ[31]}}, r_integ} + inc;
        iup     = {{(PW-32){i_cfg.upper[15]}}, i_cfg.upper, 16'h0};
        ilo     = {{(PW-32){i_cfg.lower[15]}}, i_cfg.lower, 16'h0};
        if (isum > iup) begin
            integ_n = iup[31:0];
        end else if (isum < ilo) begin
            integ_n = ilo[31:0];
        end else begin
            integ_n = isum[31:0];
        end
    end

    always_comb begin
        drv_pre = r_acc + PW'(24'h800000);
        drv_sh  = drv_pre >>> 24;
        dup     = {{(PW-16){i_cfg.upper[15]}}, i_cfg.upper};
        dlo     = {{(PW-16){i_cfg.lower[15]}}, i_cfg.lower};
        if (drv_sh > dup) begin
            drive_n = i_cfg.upper;
        end else if (drv_sh < dlo) begin
            drive_n = i_cfg.lower;
        end else begin
            drive_n = drv_sh[15:0];
        end
    end

    always_comb begin
        pwm_pre = r_prod + {{(PW-32){1'b0}}, offs};
        pwm_sh  = pwm_pre >>> 24;
        if (r_drive == 16'sd0) begin
            pwm_v = dwpp_pkg::PWM_IDLE;
        end else if (pwm_sh < 0) begin
            pwm_v = 8'd0;
        end else if (pwm_sh > PW'(255)) begin
            pwm_v = dwpp_pkg::PWM_MAX;
        end else begin
            pwm_v = pwm_sh[7:0];
        end
    end

    // one shared multiplier, operands picked by step
    always_comb begin
        case (r_state)
            L_SPD: begin
                mul_a = {3'b000, dwpp_pkg::SPD_RECIP};
                mul_b = {1'b0, r_x};
            end
            L_INT: begin
                mul_a = {1'b0, i_cfg.ki};
                mul_b = {{7{r_err[16]}}, r_err};
            end
            L_PROP: begin
                mul_a = {1'b0, i_cfg.kp};
                mul_b = {{7{r_err[16]}}, r_err};
            end
            L_DER: begin
                mul_a = {1'b0, i_cfg.kd};
                mul_b = {{6{r_derr[17]}}, r_derr};
            end
            L_PWM: begin
                mul_a = {13'b0, coef};
                mul_b = {{7{r_s[16]}}, r_s};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_prev  <= '0;
            r_integ <= '0;
            r_perr  <= '0;
        end else begin
            // hold the last product while the finished result waits
            if (r_state != L_FIN) begin
                r_prod <= mul_p;
            end
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_prev   <= i_count;
                        r_target <= i_target;
                        r_neg    <= delta[15];
                        r_x      <= x_in;
                        r_state  <= L_SPD;
                    end
                end
                L_SPD: begin
                    r_state <= L_QUOT;
                end
                L_QUOT: begin
                    r_speed <= spd_sat;
                    r_err   <= err;
                    r_state <= L_INT;
                end
                L_INT: begin
                    r_derr  <= {r_err[16], r_err} - {r_perr[16], r_perr};
                    r_perr  <= r_err;
                    r_state <= L_PROP;
                end
                L_PROP: begin
                    r_integ <= integ_n;
                    r_state <= L_DER;
                end
                L_DER: begin
                    r_acc   <= r_prod + {{(PW-40){r_integ[31]}}, r_integ, 8'h0};
                    r_state <= L_SUM;
                end
                L_SUM: begin
                    r_acc   <= r_acc - r_prod;
                    r_state <= L_DRV;
                end
                L_DRV: begin
                    r_drive <= drive_n;
                    r_s     <= {r_speed[15], r_speed} + {drive_n[15], drive_n};
                    r_state <= L_PWM;
                end
                L_PWM: begin
                    r_state <= L_FIN;
                end
                L_FIN: begin
                    // hold the finished result until the merge stage takes it
                    if (i_take) begin
                        r_state <= L_IDLE;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done      = (r_state == L_FIN);
    assign o_res.pwm   = pwm_v;
    assign o_res.drive = r_drive;

endmodule
`default_nettype wire

FILE: design/dwpp_merge.sv
`default_nettype none
module dwpp_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_restart,
    output logic                      o_stall,
    output logic                      o_start,
    input  wire logic                 i_done_a,
    input  wire logic                 i_done_b,
    input  wire dwpp_pkg::t_lane_res  i_res_a,
    input  wire dwpp_pkg::t_lane_res  i_res_b,
    output logic                      o_take,
    output logic                      o_valid,
    output dwpp_pkg::t_out_beat       o_out,
    input  wire logic                 i_stall
);

    logic                               r_busy;
    logic                               r_restart;
    logic [dwpp_pkg::RAMP_W-1:0]        r_ramp;
    logic                               r_valid;
    dwpp_pkg::t_out_beat                r_out;

    logic                               load;
    logic [dwpp_pkg::RAMP_W-1:0]        ramp_cur;
    dwpp_pkg::t_out_beat                n_out;

    assign o_start = i_valid && !r_busy;
    assign load    = r_busy && i_done_a && i_done_b && (!r_valid || !i_stall);

    // a restart reloads the counter before this tick looks at it
    always_comb begin
        ramp_cur      = r_restart ? dwpp_pkg::RAMP_STEPS : r_ramp;
        n_out.drive_a = i_res_a.drive;
        n_out.drive_b = i_res_b.drive;
        if (ramp_cur != '0) begin
            n_out.pwm_a   = dwpp_pkg::ramp_pwm(ramp_cur);
            n_out.pwm_b   = dwpp_pkg::ramp_pwm(ramp_cur);
            n_out.ramping = 1'b1;
        end else begin
            n_out.pwm_a   = i_res_a.pwm;
            n_out.pwm_b   = i_res_b.pwm;
            n_out.ramping = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ramp  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_start) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_valid <= 1'b1;
                r_ramp  <= (ramp_cur != '0) ? ramp_cur - 1'b1 : ramp_cur;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_start) begin
            r_restart <= i_restart;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_stall = r_busy;
    assign o_take  = load;
    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule
`default_nettype wire

FILE: design/dual_wheel_pid_pwm.sv
// Each lane steps through L_SPD, L_QUOT, L_INT, L_PROP, L_DER, L_SUM, L_DRV, L_PWM and
// L_FIN before the result beat is registered; a new input beat is accepted only after
// both lanes hand over. Both wheels run in their own lane, whose sequencer steps its own
// 33x24 multiplier through five products per tick; the output register frees the lanes early.
// Reset (synchronous, active low) loads the register defaults and clears all
// controller state: previous counts, integrals, previous errors, ramp count.
`default_nettype none
module dual_wheel_pid_pwm (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire dwpp_pkg::t_in_beat   i_in,
    output logic                      o_stall,
    output logic                      o_valid,
    output dwpp_pkg::t_out_beat       o_out,
    input  wire logic                 i_stall,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    logic [31:0]        r_kp_a;
    logic [31:0]        r_kp_b;
    logic [31:0]        r_ki;
    logic [31:0]        r_kd;
    logic signed [15:0] r_upper;
    logic signed [15:0] r_lower;

    dwpp_pkg::t_pid_cfg  cfg_a;
    dwpp_pkg::t_pid_cfg  cfg_b;
    dwpp_pkg::t_lane_res res_a;
    dwpp_pkg::t_lane_res res_b;
    logic                start;
    logic                take;
    logic                done_a;
    logic                done_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_a  <= dwpp_pkg::RST_PROP;
            r_kp_b  <= dwpp_pkg::RST_PROP;
            r_ki    <= dwpp_pkg::RST_INTEG;
            r_kd    <= dwpp_pkg::RST_DERIV;
            r_upper <= dwpp_pkg::RST_UPPER;
            r_lower <= dwpp_pkg::RST_LOWER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dwpp_pkg::CFG_PROP_A: r_kp_a  <= i_cfg_data;
                dwpp_pkg::CFG_PROP_B: r_kp_b  <= i_cfg_data;
                dwpp_pkg::CFG_INTEG:  r_ki    <= i_cfg_data;
                dwpp_pkg::CFG_DERIV:  r_kd    <= i_cfg_data;
                dwpp_pkg::CFG_UPPER:  r_upper <= i_cfg_data[15:0];
                dwpp_pkg::CFG_LOWER:  r_lower <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg_a.kp    = r_kp_a;
        cfg_a.ki    = r_ki;
        cfg_a.kd    = r_kd;
        cfg_a.upper = r_upper;
        cfg_a.lower = r_lower;
        cfg_b       = cfg_a;
        cfg_b.kp    = r_kp_b;
    end

    dwpp_lane u_lane_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sel_b  (1'b0),
        .i_count  (i_in.count_a),
        .i_target (i_in.target_a),
        .i_cfg    (cfg_a),
        .i_take   (take),
        .o_done   (done_a),
        .o_res    (res_a)
    );

    dwpp_lane u_lane_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sel_b  (1'b1),
        .i_count  (i_in.count_b),
        .i_target (i_in.target_b),
        .i_cfg    (cfg_b),
        .i_take   (take),
        .o_done   (done_b),
        .o_res    (res_b)
    );

    dwpp_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_restart (i_in.ramp_restart),
        .o_stall   (o_stall),
        .o_start   (start),
        .i_done_a  (done_a),
        .i_done_b  (done_b),
        .i_res_a   (res_a),
        .i_res_b   (res_b),
        .o_take    (take),
        .o_valid   (o_valid),
        .o_out     (o_out),
        .i_stall   (i_stall)
    );

endmodule
`default_nettype wire

FILE: design/dwpp_checker.sv
`default_nettype none
module dwpp_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire dwpp_pkg::t_in_beat   i_in,
    input wire logic                 o_stall,
    input wire logic                 o_valid,
    input wire dwpp_pkg::t_out_beat  o_out,
    input wire logic                 i_stall
);

    // a held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // an accepted beat sets the input stall
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // the ramp drives both wheels with the same table value
    a_ramp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.ramping |->
            (o_out.pwm_a == o_out.pwm_b) && (o_out.pwm_a >= 8'd175))
        else $error("ramp pwm mismatch");

    // a zero drive outside the ramp parks the wheel at its idle compare
    a_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.ramping && (o_out.drive_a == 16'sd0) |->
            o_out.pwm_a == dwpp_pkg::PWM_IDLE)
        else $error("zero drive did not give idle pwm");

endmodule

bind dual_wheel_pid_pwm dwpp_checker u_dwpp_checker (.*);
`default_nettype wire
